/* design/spe_pkg.sv */
// Shared types, opcodes and constants of the stack program executor.
package spe_pkg;

    localparam int STACK_DEPTH_DEFAULT = 128;
    localparam int WORD_W              = 32;
    localparam int LINE_W              = 31;
    localparam int MODE_W              = 4;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH   = 4'd0,
        OP_POP    = 4'd1,
        OP_DUP    = 4'd2,
        OP_ADD    = 4'd3,
        OP_SUB    = 4'd4,
        OP_PRINTV = 4'd5,
        OP_IN     = 4'd6,
        OP_BIZ    = 4'd7,
        OP_BINZ   = 4'd8,
        OP_JMP    = 4'd9,
        OP_END    = 4'd10
    } op_t;

    // Per-cell move: keep, take from the cell above (toward top), take from below.
    typedef enum logic [1:0] {
        SHIFT_HOLD = 2'd0,
        SHIFT_DOWN = 2'd1,
        SHIFT_UP   = 2'd2
    } shift_t;

    typedef struct packed {
        shift_t top_op;
        shift_t rest_op;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] shown_value;
        logic                     show_valid;
        logic                     branch_taken;
        logic [LINE_W-1:0]        target_line;
        logic                     halt;
        logic                     overflow_flag;
        logic                     underflow_flag;
        logic                     empty_read_flag;
        logic                     unknown_flag;
    } result_t;

endpackage

/* design/stack_program_executor_top.sv */
// Top level of the stack program executor.
//
// Input channel (in_valid/in_ready) carries one decoded instruction: mode,
// operand and entered_value. Output channel (out_valid/out_ready) returns
// exactly one result per instruction, in order.
// The operand stack is a row of STACK_DEPTH cells with the top in cell 0;
// every stack-changing instruction moves all cells at once (shift down on
// push, up on pop, top reload plus shift up on add/sub), so any instruction
// completes in the transfer cycle.
// Each result is registered in the output buffer at its input transfer.
// The executor takes one instruction per cycle while in_ready is high, as
// the cell row and stack pointer update at every transfer.
// A two-entry output buffer (register plus skid stage) lets one more
// instruction in while a result waits; in_ready drops only when both are
// full, and no result is lost or repeated while the receiver stalls.
// Reset empties the stack (pointer to zero) and clears both output entries;
// cell contents are not reset and are never read before being written.
module stack_program_executor_top #(
    parameter int STACK_DEPTH = spe_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [spe_pkg::MODE_W-1:0]        mode,
    input  logic [spe_pkg::LINE_W-1:0]        operand,
    input  logic [spe_pkg::LINE_W-1:0]        entered_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [spe_pkg::WORD_W-1:0] shown_value,
    output logic                              show_valid,
    output logic                              branch_taken,
    output logic [spe_pkg::LINE_W-1:0]        target_line,
    output logic                              halt,
    output logic                              overflow_flag,
    output logic                              underflow_flag,
    output logic                              empty_read_flag,
    output logic                              unknown_flag
);
    import spe_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic              fire;
    cell_ctrl_t        ctrl;
    logic [WORD_W-1:0] new_top;
    logic [WORD_W-1:0] cell_data [STACK_DEPTH];
    result_t           exec_result;
    result_t           out_data;

    assign fire = in_valid && in_ready;

    spe_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .SP_W        (SP_W)
    ) u_exec (
        .fire          (fire),
        .mode          (mode),
        .operand       (operand),
        .entered_value (entered_value),
        .top0          (cell_data[0]),
        .top1          (cell_data[1]),
        .sp            (sp_reg),
        .ctrl          (ctrl),
        .new_top       (new_top),
        .sp_next       (sp_next),
        .result        (exec_result)
    );

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [WORD_W-1:0] up_data;
            logic [WORD_W-1:0] down_data;
            shift_t            op;

            if (gi == 0)
            begin : g_first
                assign up_data = new_top;
                assign op      = ctrl.top_op;
            end
            else
            begin : g_inner
                assign up_data = cell_data[gi-1];
                assign op      = ctrl.rest_op;
            end

            if (gi == STACK_DEPTH - 1)
            begin : g_last
                assign down_data = cell_data[gi];
            end
            else
            begin : g_mid
                assign down_data = cell_data[gi+1];
            end

            spe_cell u_cell (
                .clk       (clk),
                .op        (op),
                .up_data   (up_data),
                .down_data (down_data),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    spe_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (exec_result),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign shown_value     = out_data.shown_value;
    assign show_valid      = out_data.show_valid;
    assign branch_taken    = out_data.branch_taken;
    assign target_line     = out_data.target_line;
    assign halt            = out_data.halt;
    assign overflow_flag   = out_data.overflow_flag;
    assign underflow_flag  = out_data.underflow_flag;
    assign empty_read_flag = out_data.empty_read_flag;
    assign unknown_flag    = out_data.unknown_flag;

endmodule

/* design/spe_cell.sv */
// One stack entry of the shift-register stack.
module spe_cell (
    input  logic                      clk,
    input  spe_pkg::shift_t           op,
    input  logic [spe_pkg::WORD_W-1:0] up_data,
    input  logic [spe_pkg::WORD_W-1:0] down_data,
    output logic [spe_pkg::WORD_W-1:0] data
);
    import spe_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    always_comb
    begin
        unique case (op)
            SHIFT_DOWN: data_next = up_data;
            SHIFT_UP:   data_next = down_data;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* design/spe_exec.sv */
// Instruction decode and execute against the two top stack cells.
module spe_exec #(
    parameter int STACK_DEPTH = spe_pkg::STACK_DEPTH_DEFAULT,
    parameter int SP_W        = $clog2(STACK_DEPTH + 1)
) (
    input  logic                        fire,
    input  logic [spe_pkg::MODE_W-1:0]  mode,
    input  logic [spe_pkg::LINE_W-1:0]  operand,
    input  logic [spe_pkg::LINE_W-1:0]  entered_value,
    input  logic [spe_pkg::WORD_W-1:0]  top0,
    input  logic [spe_pkg::WORD_W-1:0]  top1,
    input  logic [SP_W-1:0]             sp,
    output spe_pkg::cell_ctrl_t         ctrl,
    output logic [spe_pkg::WORD_W-1:0]  new_top,
    output logic [SP_W-1:0]             sp_next,
    output spe_pkg::result_t            result
);
    import spe_pkg::*;

    logic              full;
    logic              empty;
    logic              has_two;
    logic [WORD_W-1:0] top_val;
    logic [WORD_W-1:0] sec_val;
    logic              taken;
    cell_ctrl_t        ctrl_raw;
    logic [SP_W-1:0]   sp_calc;

    assign full    = (sp == SP_W'(STACK_DEPTH));
    assign empty   = (sp == '0);
    assign has_two = (sp >= SP_W'(2));
    assign top_val = empty ? '0 : top0;
    assign sec_val = has_two ? top1 : '0;

    always_comb
    begin
        ctrl_raw = '{top_op: SHIFT_HOLD, rest_op: SHIFT_HOLD};
        new_top  = '0;
        sp_calc  = sp;
        taken    = 1'b0;
        result   = '0;
        unique case (mode)
            OP_PUSH, OP_IN, OP_DUP:
            begin
                if (mode == OP_DUP)
                begin
                    new_top                = top_val;
                    result.empty_read_flag = empty;
                end
                else if (mode == OP_IN)
                begin
                    new_top = {1'b0, entered_value};
                end
                else
                begin
                    new_top = {1'b0, operand};
                end
                if (full)
                begin
                    result.overflow_flag = 1'b1;
                end
                else
                begin
                    ctrl_raw = '{top_op: SHIFT_DOWN, rest_op: SHIFT_DOWN};
                    sp_calc  = sp + SP_W'(1);
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    result.underflow_flag = 1'b1;
                end
                else
                begin
                    ctrl_raw = '{top_op: SHIFT_UP, rest_op: SHIFT_UP};
                    sp_calc  = sp - SP_W'(1);
                end
            end
            OP_ADD, OP_SUB:
            begin
                // pop two, push one: load the top cell, shift the rest up
                new_top               = (mode == OP_ADD) ? (sec_val + top_val)
                                                         : (top_val - sec_val);
                result.underflow_flag = !has_two;
                ctrl_raw              = '{top_op: SHIFT_DOWN, rest_op: SHIFT_UP};
                sp_calc               = has_two ? (sp - SP_W'(1)) : SP_W'(1);
            end
            OP_PRINTV:
            begin
                result.shown_value     = top_val;
                result.show_valid      = 1'b1;
                result.empty_read_flag = empty;
            end
            OP_BIZ:
            begin
                taken                  = (top_val == '0);
                result.empty_read_flag = empty;
            end
            OP_BINZ:
            begin
                taken                  = (top_val != '0);
                result.empty_read_flag = empty;
            end
            OP_JMP:
            begin
                taken = 1'b1;
            end
            OP_END:
            begin
                result.halt = 1'b1;
            end
            default:
            begin
                result.halt         = 1'b1;
                result.unknown_flag = 1'b1;
            end
        endcase
        result.branch_taken = taken;
        result.target_line  = taken ? operand : '0;
    end

    // Apply stack changes only on an input transfer.
    assign ctrl    = fire ? ctrl_raw : cell_ctrl_t'{top_op: SHIFT_HOLD, rest_op: SHIFT_HOLD};
    assign sp_next = fire ? sp_calc : sp;

endmodule

/* design/spe_outbuf.sv */
// Output register with skid stage for the result channel.
module spe_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  spe_pkg::result_t push_data,
    output logic             can_push,
    output logic             out_valid,
    input  logic             out_ready,
    output spe_pkg::result_t out_data
);
    import spe_pkg::*;

    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    logic    pop;

    assign pop      = main_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || pop)
        begin
            // advance the skid entry first, else take the new result
            main_next       = skid_valid_reg ? skid_reg : push_data;
            main_valid_next = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
